@@ rtl/core/mctp_pkg.sv @@
package mctp_pkg;

   // default pool geometry
   localparam int SLOTS_DEF   = 8;
   localparam int ID_BITS_DEF = 8;

   // field widths
   localparam int ID_W    = 8;
   localparam int TIME_W  = 32;
   localparam int CSR_W   = 4;

   // slot count after reset
   localparam logic [CSR_W-1:0] CSR_RESET = 4'd8;

   // request codes carried in req_tuser
   localparam logic [1:0] MODE_SUB   = 2'd0;
   localparam logic [1:0] MODE_UNSUB = 2'd1;
   localparam logic [1:0] MODE_TICK  = 2'd2;

   // result codes carried in rsp_tuser
   localparam logic [1:0] KIND_SUB    = 2'd0;
   localparam logic [1:0] KIND_UNSUB  = 2'd1;
   localparam logic [1:0] KIND_EXPIRY = 2'd2;

   // one slot as held in the slot memory
   typedef struct packed {
      logic [ID_W-1:0]   client;
      logic              rep;
      logic [TIME_W-1:0] start;
      logic [TIME_W-1:0] period;
   } slot_word_type;

   // compare unit verdict for one slot
   typedef struct packed {
      logic id_match;
      logic expired;
   } cmp_res_type;

endpackage

@@ rtl/core/mctp_ram.sv @@
module mctp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/mctp_cmp.sv @@
module mctp_cmp
   import mctp_pkg::*;
(
   input  logic [TIME_W-1:0] tick,
   input  logic [ID_W-1:0]   id,
   input  slot_word_type     word,
   output cmp_res_type       res
);

   logic [TIME_W-1:0] end_time;

   // wrapping end time, plain unsigned compare against the counter
   always_comb begin
      end_time     = word.start + word.period;
      res.expired  = (tick >= end_time);
      res.id_match = (word.client == id);
   end

endmodule

@@ rtl/core/multi_client_tick_timer_pool.sv @@
// Pool of timer slots driven by a tick request stream.
// req channel: tuser selects subscribe, unsubscribe or tick; tdata carries the
// client id, period and repeat flag. One transaction is taken when req_tready
// is high, which is the case only while no request is in progress.
// rsp channel: tuser gives the result kind, tdata the accepted flag, client id
// and counter value, tlast marks the final result of a request. A tick that
// expires no slot returns nothing; an unused request code is dropped.
// Sequence: with n = min(slots_in_use, SLOTS), a request starts the slot read
// in RD, scans up to n slots in EV and finishes in FIN; the next request is
// taken once the sequencer is back in IDLE.
// The single read port of the slot memory feeds the shared end-time adder
// and comparator one slot per cycle while the scan is not held; subscribe and
// unsubscribe stop at the slot that holds the client.
// A result waits in an output register and one expiry notice is held back,
// so a stalled receiver holds the scan only when an expiry is found while both
// are full; the finishing cycle waits until the output register is free.
// Reset: counter zero, slots_in_use 8, every slot free, at once (occupancy is
// held in flops). Writing csr_wr_data sets slots_in_use and frees all slots;
// it must be written only while the block is idle; the block does not check.
module multi_client_tick_timer_pool
   import mctp_pkg::*;
#(
   parameter int SLOTS   = SLOTS_DEF,
   parameter int ID_BITS = ID_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   // request: tdata = client_id[7:0], period[39:8], repeat_req[40], zero pad
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [47:0]      req_tdata,
   // request: tuser = mode[1:0]
   input  logic [1:0]       req_tuser,
   // result: tdata = accepted[0], client_id_res[8:1], time_now[40:9], zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [47:0]      rsp_tdata,
   // result: tuser = kind[1:0]
   output logic [1:0]       rsp_tuser,
   output logic             rsp_tlast,
   // slots_in_use register
   input  logic             csr_wr_en,
   input  logic [CSR_W-1:0] csr_wr_data
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [ID_W-1:0] ID_MASK =
      (ID_BITS >= ID_W) ? {ID_W{1'b1}} : ID_W'((1 << ID_BITS) - 1);

   typedef enum logic [1:0] {IDLE, RD, EV, FIN} state_type;

   state_type         state_ff;
   logic [CSR_W-1:0]  csr_ff;
   logic [TIME_W-1:0] tick_ff;
   logic [SLOTS-1:0]  valid_ff;
   logic [1:0]        mode_ff;
   logic [ID_W-1:0]   id_ff;
   logic [TIME_W-1:0] period_ff;
   logic              rep_ff;
   logic [IW-1:0]     idx_ff;
   logic [IW-1:0]     free_idx_ff;
   logic              free_found_ff;
   logic              hit_ff;
   logic              pend_vld_ff;
   logic [ID_W-1:0]   pend_id_ff;
   logic              rsp_valid_ff;
   logic [1:0]        rsp_kind_ff;
   logic              rsp_acc_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   logic [TIME_W-1:0] rsp_time_ff;
   logic              rsp_last_ff;

   logic [CW-1:0]     n_eff;
   logic              req_acc;
   logic [ID_W-1:0]   req_id;
   logic              out_free;
   logic              last_slot;
   logic              slot_hit;
   logic              slot_exp;
   logic              ev_stall;
   logic              ev_stop;
   logic              ev_adv;
   logic              rsp_load;
   logic              ram_wr_en;
   logic [IW-1:0]     ram_wr_addr;
   slot_word_type     ram_wr_data;
   logic              ram_rd_en;
   logic [IW-1:0]     ram_rd_addr;
   slot_word_type     ram_rd_data;
   cmp_res_type       cmp_res;

   // slot memory
   mctp_ram #(
      .WIDTH($bits(slot_word_type)),
      .DEPTH(SLOTS)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_en  (ram_rd_en),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   // shared end-time and id compare
   mctp_cmp u_cmp (
      .tick(tick_ff),
      .id  (id_ff),
      .word(ram_rd_data),
      .res (cmp_res)
   );

   // scan control
   always_comb begin
      if (32'(csr_ff) > SLOTS) begin
         n_eff = CW'(SLOTS);
      end else begin
         n_eff = CW'(csr_ff);
      end
      req_acc   = req_tvalid && req_tready;
      req_id    = req_tdata[7:0] & ID_MASK;
      out_free  = !rsp_valid_ff || rsp_tready;
      last_slot = (CW'(idx_ff) == n_eff - CW'(1));
      slot_hit  = valid_ff[idx_ff] && cmp_res.id_match;
      slot_exp  = valid_ff[idx_ff] && cmp_res.expired;
      ev_stall  = (mode_ff == MODE_TICK) && slot_exp && pend_vld_ff && !out_free;
      ev_stop   = ((mode_ff == MODE_SUB) || (mode_ff == MODE_UNSUB)) && slot_hit;
      ev_adv    = (state_ff == EV) && !ev_stall && !ev_stop;
      // output register takes a new result this cycle
      rsp_load  = (ev_adv && (mode_ff == MODE_TICK) && slot_exp && pend_vld_ff) ||
                  ((state_ff == FIN) && out_free &&
                   !((mode_ff == MODE_TICK) && !pend_vld_ff));
   end

   // slot memory access
   always_comb begin
      ram_rd_en   = (state_ff == RD) || (ev_adv && !last_slot);
      ram_rd_addr = (state_ff == RD) ? idx_ff : idx_ff + IW'(1);
      ram_wr_en   = ((state_ff == EV) && (mode_ff == MODE_SUB) && slot_hit) ||
                    ((state_ff == EV) && (mode_ff == MODE_TICK) && slot_exp &&
                     !ev_stall && ram_rd_data.rep) ||
                    ((state_ff == FIN) && (mode_ff == MODE_SUB) && !hit_ff &&
                     free_found_ff && out_free);
      ram_wr_addr = (state_ff == FIN) ? free_idx_ff : idx_ff;
      ram_wr_data.client = id_ff;
      ram_wr_data.start  = tick_ff;
      if (mode_ff == MODE_TICK) begin
         ram_wr_data.client = ram_rd_data.client;
         ram_wr_data.rep    = ram_rd_data.rep;
         ram_wr_data.period = ram_rd_data.period;
      end else begin
         ram_wr_data.rep    = rep_ff;
         ram_wr_data.period = period_ff;
      end
   end

   // sequencer, occupancy and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         csr_ff        <= CSR_RESET;
         tick_ff       <= '0;
         valid_ff      <= '0;
         pend_vld_ff   <= 1'b0;
         free_found_ff <= 1'b0;
         hit_ff        <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_tready && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end
         // register write frees the pool
         if (csr_wr_en) begin
            csr_ff   <= csr_wr_data;
            valid_ff <= '0;
         end
         unique case (state_ff)
            IDLE: begin
               if (req_acc) begin
                  mode_ff       <= req_tuser;
                  id_ff         <= req_id;
                  period_ff     <= req_tdata[39:8];
                  rep_ff        <= req_tdata[40];
                  idx_ff        <= '0;
                  free_found_ff <= 1'b0;
                  hit_ff        <= 1'b0;
                  pend_vld_ff   <= 1'b0;
                  if (req_tuser == MODE_TICK) begin
                     tick_ff <= tick_ff + TIME_W'(1);
                  end
                  priority if ((req_tuser != MODE_SUB) && (req_tuser != MODE_UNSUB) &&
                               (req_tuser != MODE_TICK)) begin
                     state_ff <= IDLE;
                  end else if ((req_tuser != MODE_TICK) && (req_id == '0)) begin
                     state_ff <= FIN;
                  end else if (n_eff == '0) begin
                     state_ff <= FIN;
                  end else begin
                     state_ff <= RD;
                  end
               end
            end
            RD: begin
               state_ff <= EV;
            end
            EV: begin
               if (ev_stop) begin
                  if (mode_ff == MODE_SUB) begin
                     hit_ff <= 1'b1;
                  end else begin
                     valid_ff[idx_ff] <= 1'b0;
                  end
                  state_ff <= FIN;
               end else if (ev_adv) begin
                  // lowest free slot for a later claim
                  if ((mode_ff == MODE_SUB) && !valid_ff[idx_ff] && !free_found_ff) begin
                     free_idx_ff   <= idx_ff;
                     free_found_ff <= 1'b1;
                  end
                  // expiry: flush the held notice, hold this one
                  if ((mode_ff == MODE_TICK) && slot_exp) begin
                     if (pend_vld_ff) begin
                        rsp_valid_ff <= 1'b1;
                        rsp_kind_ff  <= KIND_EXPIRY;
                        rsp_acc_ff   <= 1'b1;
                        rsp_id_ff    <= pend_id_ff;
                        rsp_time_ff  <= tick_ff;
                        rsp_last_ff  <= 1'b0;
                     end
                     pend_id_ff  <= ram_rd_data.client;
                     pend_vld_ff <= 1'b1;
                     if (!ram_rd_data.rep) begin
                        valid_ff[idx_ff] <= 1'b0;
                     end
                  end
                  if (last_slot) begin
                     state_ff <= FIN;
                  end else begin
                     idx_ff <= idx_ff + IW'(1);
                  end
               end
            end
            FIN: begin
               if ((mode_ff == MODE_TICK) && !pend_vld_ff) begin
                  state_ff <= IDLE;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_time_ff  <= tick_ff;
                  rsp_last_ff  <= 1'b1;
                  if (mode_ff == MODE_SUB) begin
                     rsp_kind_ff <= KIND_SUB;
                     rsp_acc_ff  <= hit_ff || free_found_ff;
                     rsp_id_ff   <= id_ff;
                     if (!hit_ff && free_found_ff) begin
                        valid_ff[free_idx_ff] <= 1'b1;
                     end
                  end else if (mode_ff == MODE_UNSUB) begin
                     rsp_kind_ff <= KIND_UNSUB;
                     rsp_acc_ff  <= 1'b1;
                     rsp_id_ff   <= id_ff;
                  end else begin
                     rsp_kind_ff <= KIND_EXPIRY;
                     rsp_acc_ff  <= 1'b1;
                     rsp_id_ff   <= pend_id_ff;
                     pend_vld_ff <= 1'b0;
                  end
                  state_ff <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0, rsp_time_ff, rsp_id_ff, rsp_acc_ff};

`ifndef NO_ASSERTIONS
   // scan index stays inside the searched range
   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == EV) |-> (CW'(idx_ff) < n_eff))
      else $error("scan index beyond slots in use");

   // a tick advances the counter by exactly one
   a_tick_step: assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_tuser == MODE_TICK)) |=> (tick_ff == $past(tick_ff) + TIME_W'(1)))
      else $error("tick counter did not advance by one");

   // held expiry notices belong to tick requests only
   a_pend_tick: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> (mode_ff == MODE_TICK))
      else $error("pending expiry outside a tick");

   // subscribe and unsubscribe give a single closing result
   a_single_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_kind_ff != KIND_EXPIRY)) |-> rsp_last_ff)
      else $error("status result without tlast");
`endif

endmodule
